// ===== rtl/uartrb_pkg.sv =====
// Shared types and constants of the UART ring buffer block.
`default_nettype none
package uartrb_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_RX_BYTE  = 2'd0,
    OP_RX_READ  = 2'd1,
    OP_TX_WRITE = 2'd2,
    OP_TX_READY = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_RX_OVERFLOW = 3'd1,
    ST_FRAME       = 3'd2,
    ST_OVERRUN     = 3'd3,
    ST_RX_EMPTY    = 3'd4,
    ST_TX_FULL     = 3'd5,
    ST_WOULD_BLOCK = 3'd6
  } status_e;

  // Bit positions in the latched receive error word.
  localparam int unsigned ErrFrameBit    = 0;
  localparam int unsigned ErrOverrunBit  = 1;
  localparam int unsigned ErrOverflowBit = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted input item
    logic exec;  // apply the item to the rings and form the result
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/uartrb_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`default_nettype none
module uartrb_ctrl import uartrb_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Handshake and command outputs.
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec  = (state_q == S_EXEC);

endmodule
`default_nettype wire

// ===== rtl/uartrb_datapath.sv =====
// Ring pointers, byte stores, error and watch flags, and the result register.
`default_nettype none
module uartrb_datapath import uartrb_pkg::*; #(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire ctrl_cmd_t cmd_i,
  input  wire [1:0]  op_i,
  input  wire [7:0]  data_i,
  input  wire        frame_error_i,
  input  wire        data_overrun_i,
  input  wire        block_when_full_i,
  input  wire        cfg_we_i,
  input  wire [7:0]  cfg_wdata_i,
  output logic [7:0] watch_byte_o,
  output logic [2:0] status_o,
  output logic [7:0] data_out_o,
  output logic       data_valid_o,
  output logic       watch_seen_o,
  output logic       tx_request_o
);

  localparam int unsigned RxW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned TxW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RxW-1:0] RxLast = RxW'(RX_DEPTH - 1);
  localparam logic [TxW-1:0] TxLast = TxW'(TX_DEPTH - 1);

  // Captured input item.
  op_e        op_q;
  logic [7:0] data_q;
  logic       fe_q, dor_q, blk_q;

  // Ring state.
  logic [RxW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [TxW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [2:0]     err_q, err_d;
  logic           watch_flag_q, watch_flag_d;
  logic           tx_en_q, tx_en_d;
  logic [7:0]     watch_byte_q;

  // Byte stores with registered read data.
  logic [7:0] rx_mem_q [RX_DEPTH];
  logic [7:0] tx_mem_q [TX_DEPTH];
  logic [7:0] rx_rd_q, tx_rd_q;

  // Result register.
  status_e status_q, status_d;
  logic    valid_q, valid_d;
  logic    pop_rx_q, pop_rx_d;

  logic [RxW-1:0] rx_head_nxt, rx_tail_nxt;
  logic [TxW-1:0] tx_head_nxt, tx_tail_nxt;
  logic           rx_empty, rx_full, tx_empty, tx_full;
  logic           rx_store_en, tx_store_en;

  // Pointer successors and ring conditions.
  assign rx_head_nxt = (rx_head_q == RxLast) ? '0 : rx_head_q + 1'b1;
  assign rx_tail_nxt = (rx_tail_q == RxLast) ? '0 : rx_tail_q + 1'b1;
  assign tx_head_nxt = (tx_head_q == TxLast) ? '0 : tx_head_q + 1'b1;
  assign tx_tail_nxt = (tx_tail_q == TxLast) ? '0 : tx_tail_q + 1'b1;
  assign rx_empty    = (rx_head_q == rx_tail_q);
  assign rx_full     = (rx_head_nxt == rx_tail_q);
  assign tx_empty    = (tx_head_q == tx_tail_q);
  assign tx_full     = (tx_head_nxt == tx_tail_q);
  assign rx_store_en = cmd_i.exec && (op_q == OP_RX_BYTE) && !rx_full;
  assign tx_store_en = cmd_i.exec && (op_q == OP_TX_WRITE) && !tx_full;

  // Item capture; the payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      data_q <= data_i;
      fe_q   <= frame_error_i;
      dor_q  <= data_overrun_i;
      blk_q  <= block_when_full_i;
    end
  end

  // Effect of one item on the rings and the result.
  always_comb begin
    rx_head_d    = rx_head_q;
    rx_tail_d    = rx_tail_q;
    tx_head_d    = tx_head_q;
    tx_tail_d    = tx_tail_q;
    err_d        = err_q;
    watch_flag_d = watch_flag_q;
    tx_en_d      = tx_en_q;
    status_d     = status_q;
    valid_d      = valid_q;
    pop_rx_d     = pop_rx_q;
    if (cmd_i.exec) begin
      status_d = ST_OK;
      valid_d  = 1'b0;
      pop_rx_d = 1'b0;
      unique case (op_q)
        OP_RX_BYTE: begin
          err_d = '0;
          err_d[ErrFrameBit]   = fe_q;
          err_d[ErrOverrunBit] = dor_q;
          if (!rx_full) begin
            rx_head_d = rx_head_nxt;
            if (data_q == watch_byte_q) watch_flag_d = 1'b1;
          end else begin
            err_d[ErrOverflowBit] = 1'b1;
            status_d = ST_RX_OVERFLOW;
          end
        end
        OP_RX_READ: begin
          if (rx_empty) begin
            status_d = ST_RX_EMPTY;
          end else begin
            rx_tail_d = rx_tail_nxt;
            valid_d   = 1'b1;
            pop_rx_d  = 1'b1;
            // Report the latest receive error by priority.
            priority if (err_q[ErrOverflowBit]) status_d = ST_RX_OVERFLOW;
            else if (err_q[ErrFrameBit])        status_d = ST_FRAME;
            else if (err_q[ErrOverrunBit])      status_d = ST_OVERRUN;
            else                                status_d = ST_OK;
          end
        end
        OP_TX_WRITE: begin
          if (tx_full) begin
            status_d = blk_q ? ST_WOULD_BLOCK : ST_TX_FULL;
          end else begin
            tx_head_d = tx_head_nxt;
            tx_en_d   = 1'b1;
          end
        end
        OP_TX_READY: begin
          if (!tx_empty) begin
            tx_tail_d = tx_tail_nxt;
            valid_d   = 1'b1;
          end else begin
            tx_en_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q    <= '0;
      rx_tail_q    <= '0;
      tx_head_q    <= '0;
      tx_tail_q    <= '0;
      err_q        <= '0;
      watch_flag_q <= 1'b0;
      tx_en_q      <= 1'b0;
      watch_byte_q <= '0;
      status_q     <= ST_OK;
      valid_q      <= 1'b0;
      pop_rx_q     <= 1'b0;
    end else begin
      rx_head_q    <= rx_head_d;
      rx_tail_q    <= rx_tail_d;
      tx_head_q    <= tx_head_d;
      tx_tail_q    <= tx_tail_d;
      err_q        <= err_d;
      watch_flag_q <= watch_flag_d;
      tx_en_q      <= tx_en_d;
      status_q     <= status_d;
      valid_q      <= valid_d;
      pop_rx_q     <= pop_rx_d;
      if (cfg_we_i) watch_byte_q <= cfg_wdata_i;
    end
  end

  // Receive store: write at the new head, read at the next tail.
  always_ff @(posedge clk_i) begin
    if (rx_store_en) rx_mem_q[rx_head_nxt] <= data_q;
    if (cmd_i.exec)  rx_rd_q <= rx_mem_q[rx_tail_nxt];
  end

  // Transmit store: write at the new head, read at the next tail.
  always_ff @(posedge clk_i) begin
    if (tx_store_en) tx_mem_q[tx_head_nxt] <= data_q;
    if (cmd_i.exec)  tx_rd_q <= tx_mem_q[tx_tail_nxt];
  end

  // Result fields.
  assign status_o     = status_q;
  assign data_valid_o = valid_q;
  assign data_out_o   = !valid_q ? 8'h00 : (pop_rx_q ? rx_rd_q : tx_rd_q);
  assign watch_seen_o = watch_flag_q;
  assign tx_request_o = tx_en_q;
  assign watch_byte_o = watch_byte_q;

  // A read of an empty receive ring pops nothing.
  a_rx_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (op_q == OP_RX_READ) && rx_empty |=>
      (status_q == ST_RX_EMPTY) && !valid_q && $stable(rx_tail_q))
    else $error("empty rx read changed the ring or returned data");

  // Transmitter ready on an empty ring drops the request.
  a_tx_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (op_q == OP_TX_READY) && tx_empty |=> !tx_en_q && !valid_q)
    else $error("tx request not cleared on empty transmit ring");

  // A popped byte never comes with an empty or full status.
  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (status_q != ST_RX_EMPTY) && (status_q != ST_TX_FULL) &&
                (status_q != ST_WOULD_BLOCK))
    else $error("popped byte reported with a failure status");

  // The watch flag is sticky.
  a_watch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(watch_flag_q))
    else $error("watch flag cleared outside reset");

  // Pointers move only while an item executes.
  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(rx_head_q) && $stable(rx_tail_q) &&
                    $stable(tx_head_q) && $stable(tx_tail_q))
    else $error("ring pointer moved without an executing item");

endmodule
`default_nettype wire

// ===== rtl/uart_ring_buffers_with_watch_byte.sv =====
// Top level: UART receive and transmit ring buffers with a watch byte.
// Each item passes through three steps: accept, execute (ring update and store read),
// and present the result; the next item is accepted the cycle after the result
// transfer completes, so only one item is in flight at a time. The registered
// store read port sets the execute step.
// Reset (rst_ni low, asynchronous) empties both rings and clears all flags.
`default_nettype none
module uart_ring_buffers_with_watch_byte import uartrb_pkg::*; #(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input item stream.
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,   // [7:0] data, [8] frame_error,
                                        // [9] data_overrun, [10] block_when_full
  input  wire  [1:0]  s_axis_tuser_i,   // [1:0] op
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [2:0] status, [10:3] data_out,
                                        // [11] data_valid, [12] watch_seen,
                                        // [13] tx_request
  // Configuration port.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_cmd_t  cmd;
  logic [7:0] watch_byte;
  logic [2:0] status;
  logic [7:0] data_out;
  logic       data_valid, watch_seen, tx_request;
  logic       cfg_we;

  uartrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  uartrb_datapath #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .op_i              (s_axis_tuser_i),
    .data_i            (s_axis_tdata_i[7:0]),
    .frame_error_i     (s_axis_tdata_i[8]),
    .data_overrun_i    (s_axis_tdata_i[9]),
    .block_when_full_i (s_axis_tdata_i[10]),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (pwdata[7:0]),
    .watch_byte_o      (watch_byte),
    .status_o          (status),
    .data_out_o        (data_out),
    .data_valid_o      (data_valid),
    .watch_seen_o      (watch_seen),
    .tx_request_o      (tx_request)
  );

  // Register decode: the watch byte lives at addresses 0 to 3 (paddr[2] low).
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = !paddr[2] ? {24'h000000, watch_byte} : 32'h0000_0000;

  // Result packing.
  assign m_axis_tdata_o = {2'b00, tx_request, watch_seen, data_valid, data_out, status};

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the UART ring buffers with a watch byte.
`timescale 1ns / 1ps
module tb_top;
  import uartrb_pkg::*;

  localparam int unsigned RandomItems   = 1150;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned MaxReports    = 10;
  localparam logic [2:0]  AddrWatchByte = 3'd0;

  // One input event as it travels on the item stream.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       fe;
    logic       dor;
    logic       blk;
  } ring_event_t;

  // One result, laid out like m_axis_tdata_o[13:0].
  typedef struct packed {
    logic       txreq;
    logic       watch;
    logic       valid;
    logic [7:0] dout;
    status_e    status;
  } ring_result_t;

  // Directed row: an event and, where typed is set, its expected result.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       fe;
    logic       dor;
    logic       blk;
    logic       typed;
    status_e    st;
    logic [7:0] dout;
    logic       valid;
    logic       watch;
    logic       txreq;
  } dir_row_t;

  // Traffic shapes of the random part.
  typedef enum {
    MIX_RX_FILL,
    MIX_RX_DRAIN,
    MIX_TX_FILL,
    MIX_TX_DRAIN,
    MIX_ANY
  } mix_e;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;

  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [15:0] m_axis_tdata_o;
  wire  [31:0] prdata;
  wire         pready;

  uart_ring_buffers_with_watch_byte u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Shadow copy of the block state. Depth is 64, so 6-bit pointers wrap by themselves.
  logic [7:0] rx_mem [64];
  logic [7:0] tx_mem [64];
  logic [5:0] rx_wr = '0, rx_rd = '0, tx_wr = '0, tx_rd = '0;
  logic [2:0] rx_err    = '0;
  logic       watch_hit = 1'b0;
  logic       tx_req    = 1'b0;
  logic [7:0] watch_byte = 8'h00;

  ring_result_t pending_results [$];
  dir_row_t     dir_rows [$];
  logic         calm = 1'b0;
  int unsigned  mismatches   = 0;
  int unsigned  items_sent   = 0;
  int unsigned  results_seen = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  status_hist [8];

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Apply one event to the shadow rings and return the result it must produce.
  function automatic ring_result_t apply_ring_event(input ring_event_t ev);
    ring_result_t res;
    logic [2:0]   err;
    logic [5:0]   nxt;
    res = '0;
    res.status = ST_OK;
    case (ev.op)
      OP_RX_BYTE: begin
        err = '0;
        err[ErrFrameBit]   = ev.fe;
        err[ErrOverrunBit] = ev.dor;
        nxt = rx_wr + 6'd1;
        if (nxt != rx_rd) begin
          rx_wr = nxt;
          rx_mem[nxt] = ev.data;
          if (ev.data == watch_byte) watch_hit = 1'b1;
        end else begin
          err[ErrOverflowBit] = 1'b1;
          res.status = ST_RX_OVERFLOW;
        end
        rx_err = err;
      end
      OP_RX_READ: begin
        if (rx_wr == rx_rd) begin
          res.status = ST_RX_EMPTY;
        end else begin
          rx_rd = rx_rd + 6'd1;
          res.dout  = rx_mem[rx_rd];
          res.valid = 1'b1;
          // Latched flags are reported by priority and survive the read.
          if (rx_err[ErrOverflowBit])     res.status = ST_RX_OVERFLOW;
          else if (rx_err[ErrFrameBit])   res.status = ST_FRAME;
          else if (rx_err[ErrOverrunBit]) res.status = ST_OVERRUN;
        end
      end
      OP_TX_WRITE: begin
        nxt = tx_wr + 6'd1;
        if (nxt == tx_rd) begin
          res.status = ev.blk ? ST_WOULD_BLOCK : ST_TX_FULL;
        end else begin
          tx_mem[nxt] = ev.data;
          tx_wr  = nxt;
          tx_req = 1'b1;
        end
      end
      default: begin
        if (tx_wr != tx_rd) begin
          tx_rd = tx_rd + 6'd1;
          res.dout  = tx_mem[tx_rd];
          res.valid = 1'b1;
        end else begin
          tx_req = 1'b0;
        end
      end
    endcase
    res.watch = watch_hit;
    res.txreq = tx_req;
    return res;
  endfunction

  // Draw a random event, biased toward the primary operation of the traffic shape.
  function automatic ring_event_t random_event(input mix_e mix);
    ring_event_t ev;
    op_e         primary;
    case (mix)
      MIX_RX_FILL:  primary = OP_RX_BYTE;
      MIX_RX_DRAIN: primary = OP_RX_READ;
      MIX_TX_FILL:  primary = OP_TX_WRITE;
      default:      primary = OP_TX_READY;
    endcase
    if (mix == MIX_ANY || $urandom_range(99) >= 90) ev.op = op_e'($urandom_range(3));
    else ev.op = primary;
    ev.data = ($urandom_range(5) == 0) ? watch_byte : 8'($urandom_range(255));
    ev.fe   = 1'($urandom_range(1));
    ev.dor  = 1'($urandom_range(1));
    ev.blk  = 1'($urandom_range(1));
    return ev;
  endfunction

  task automatic show_mismatch(input string what, input ring_result_t exp_r,
                               input ring_result_t act_r);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("MISMATCH %s: expected st=%0d dout=%02h v=%b w=%b tx=%b,",
               what, exp_r.status, exp_r.dout, exp_r.valid, exp_r.watch, exp_r.txreq);
      $display("  got st=%0d dout=%02h v=%b w=%b tx=%b",
               act_r.status, act_r.dout, act_r.valid, act_r.watch, act_r.txreq);
    end
  endtask

  // Offer one event, with random idle cycles ahead of it, and predict at the transfer.
  task automatic send_event(input ring_event_t ev, input logic use_typed,
                            input ring_result_t typed_res);
    ring_result_t res;
    while (!calm && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, ev.blk, ev.dor, ev.fe, ev.data};
    s_tuser  <= ev.op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = apply_ring_event(ev);
    status_hist[res.status]++;
    items_sent++;
    pending_results.push_back(use_typed ? typed_res : res);
  endtask

  // Stop offering events, wait for every pending result, then let the pipeline settle.
  task automatic wait_rings_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the watch byte over the configuration port and read it back.
  task automatic set_watch_byte(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWatchByte;
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    watch_byte = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {24'h0, value}) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("MISMATCH watch byte readback: expected %08h got %08h",
                 {24'h0, value}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random stalls, and every result transfer checked against the oldest one due.
  always @(posedge clk_i) begin
    ring_result_t act_r;
    ring_result_t exp_r;
    act_r = ring_result_t'(m_axis_tdata_o[13:0]);
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        show_mismatch("result with nothing pending", '0, act_r);
      end else begin
        exp_r = pending_results.pop_front();
        if (act_r.status !== exp_r.status || act_r.dout !== exp_r.dout ||
            act_r.valid !== exp_r.valid || act_r.watch !== exp_r.watch ||
            act_r.txreq !== exp_r.txreq || m_axis_tdata_o[15:14] !== 2'b00)
          show_mismatch("result field", exp_r, act_r);
      end
    end
    if (rst_ni) m_tready <= calm || ($urandom_range(99) >= 35);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no transfer for %0d cycles", StallLimit);
      $display("uart_ring_buffers_with_watch_byte regression: fail");
      $finish;
    end
  end

  initial begin
    ring_event_t  ev;
    ring_result_t typed_res;
    dir_row_t     row;
    int           seg;
    int           seg_len;
    int unsigned  random_sent;
    mix_e         mix;

    foreach (rx_mem[i]) rx_mem[i] = 8'h00;
    foreach (tx_mem[i]) tx_mem[i] = 8'h00;
    foreach (status_hist[i]) status_hist[i] = 0;

    // Directed rows: op, data, {fe,dor,blk}, typed, status, dout, {valid,watch,txreq}.
    // Empty reads right after reset.
    dir_rows.push_back({OP_RX_READ,  8'h00, 3'b000, 1'b1, ST_RX_EMPTY, 8'h00, 3'b000});
    dir_rows.push_back({OP_TX_READY, 8'h00, 3'b000, 1'b1, ST_OK,       8'h00, 3'b000});
    // Receives: no match, then a match with a frame error, then an overrun.
    dir_rows.push_back({OP_RX_BYTE,  8'h00, 3'b000, 1'b1, ST_OK,       8'h00, 3'b000});
    dir_rows.push_back({OP_RX_BYTE,  8'hFF, 3'b100, 1'b1, ST_OK,       8'h00, 3'b010});
    dir_rows.push_back({OP_RX_BYTE,  8'h5A, 3'b010, 1'b0, ST_OK,       8'h00, 3'b000});
    dir_rows.push_back({OP_RX_READ,  8'h00, 3'b000, 1'b1, ST_OVERRUN,  8'h00, 3'b110});
    // Frame wins over overrun, and the flags survive the read.
    dir_rows.push_back({OP_RX_BYTE,  8'h33, 3'b110, 1'b0, ST_OK,       8'h00, 3'b000});
    dir_rows.push_back({OP_RX_READ,  8'h00, 3'b000, 1'b1, ST_FRAME,    8'hFF, 3'b110});
    dir_rows.push_back({OP_RX_READ,  8'hC3, 3'b111, 1'b0, ST_OK,       8'h00, 3'b000});
    dir_rows.push_back({OP_RX_BYTE,  8'h81, 3'b001, 1'b0, ST_OK,       8'h00, 3'b000});
    dir_rows.push_back({OP_RX_READ,  8'h00, 3'b000, 1'b0, ST_OK,       8'h00, 3'b000});
    dir_rows.push_back({OP_RX_READ,  8'h00, 3'b000, 1'b0, ST_OK,       8'h00, 3'b000});
    dir_rows.push_back({OP_RX_READ,  8'h00, 3'b000, 1'b1, ST_RX_EMPTY, 8'h00, 3'b010});
    // Transmit side: pushes raise the request, pops drain, an empty pop drops it.
    dir_rows.push_back({OP_TX_WRITE, 8'h00, 3'b000, 1'b1, ST_OK,       8'h00, 3'b011});
    dir_rows.push_back({OP_TX_WRITE, 8'hFF, 3'b111, 1'b0, ST_OK,       8'h00, 3'b000});
    dir_rows.push_back({OP_TX_READY, 8'h00, 3'b000, 1'b1, ST_OK,       8'h00, 3'b111});
    dir_rows.push_back({OP_TX_READY, 8'hFF, 3'b110, 1'b1, ST_OK,       8'hFF, 3'b111});
    dir_rows.push_back({OP_TX_READY, 8'h00, 3'b000, 1'b1, ST_OK,       8'h00, 3'b010});
    dir_rows.push_back({OP_TX_READY, 8'hA5, 3'b111, 1'b0, ST_OK,       8'h00, 3'b000});
    // Unused fields set on receive and read.
    dir_rows.push_back({OP_RX_BYTE,  8'hA5, 3'b001, 1'b0, ST_OK,       8'h00, 3'b000});
    dir_rows.push_back({OP_RX_READ,  8'hFF, 3'b111, 1'b0, ST_OK,       8'h00, 3'b000});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    set_watch_byte(8'hFF);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      ev.op  = row.op;
      ev.data = row.data;
      ev.fe  = row.fe;
      ev.dor = row.dor;
      ev.blk = row.blk;
      typed_res.status = row.st;
      typed_res.dout   = row.dout;
      typed_res.valid  = row.valid;
      typed_res.watch  = row.watch;
      typed_res.txreq  = row.txreq;
      send_event(ev, row.typed, typed_res);
    end
    wait_rings_idle();

    // Random segments: fill and drain each ring first, then random shapes.
    seg = 0;
    random_sent = 0;
    while (random_sent < RandomItems) begin
      case (seg)
        0:       set_watch_byte(8'h00);
        1:       set_watch_byte(8'hFF);
        default: set_watch_byte(8'($urandom_range(255)));
      endcase
      mix = (seg < 4) ? mix_e'(seg) : mix_e'($urandom_range(4));
      seg_len = (mix == MIX_ANY) ? $urandom_range(40, 100) : $urandom_range(80, 160);
      // The last segment stops at the planned item count.
      if (seg_len > int'(RandomItems - random_sent))
        seg_len = int'(RandomItems - random_sent);
      calm = (seg == 5 || seg == 6);
      repeat (seg_len) begin
        send_event(random_event(mix), 1'b0, '0);
        random_sent++;
      end
      wait_rings_idle();
      seg++;
    end
    calm = 1'b0;

    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("Sent %0d events in %0d random segments, checked %0d results.",
             items_sent, seg, results_seen);
    $display("Seen: rx overflow %0d, rx empty %0d, tx full %0d, would-block %0d.",
             status_hist[ST_RX_OVERFLOW], status_hist[ST_RX_EMPTY],
             status_hist[ST_TX_FULL], status_hist[ST_WOULD_BLOCK]);
    if (mismatches == 0) begin
      $display("uart_ring_buffers_with_watch_byte regression: pass");
    end else begin
      $display("uart_ring_buffers_with_watch_byte regression: fail");
    end
    $finish;
  end

endmodule
